>>> hw/rtl/sdio_xts_pkg.sv
// shared types, constants and helpers for the sdio extended transfer splitter
package sdio_xts_pkg;

   localparam int SIZE_BITS = 16;
   localparam int DIV_CNT_W = $clog2(SIZE_BITS + 1);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ADDR_ERR = 2'd1;
   localparam logic [1:0] STATUS_LIMIT    = 2'd2;

   localparam logic [1:0] CSR_BLOCK_SIZE   = 2'd0;
   localparam logic [1:0] CSR_BLK_MODE_EN  = 2'd1;
   localparam logic [1:0] CSR_BLK_CAP      = 2'd2;
   localparam logic [1:0] CSR_BYTE_LIMIT   = 2'd3;

   localparam logic [11:0] BLOCK_SIZE_MAX  = 12'd2048;
   localparam logic [9:0]  BYTE_CHUNK_MAX  = 10'd512;
   localparam logic [11:0] BYTE_CODE_MAX   = 12'd512;
   localparam logic [16:0] ADDR_MAX        = 17'h1FFFF;

   typedef struct packed {
      logic                 write;
      logic [2:0]           function_number;
      logic [16:0]          start_address;
      logic                 increment_address;
      logic [SIZE_BITS-1:0] transfer_size;
   } req_type;

   typedef struct packed {
      logic        command_valid;
      logic [31:0] command_argument;
      logic [15:0] payload_bytes;
      logic [19:0] bus_bytes;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] block_size;
      logic        blk_mode_en;
      logic [8:0]  blk_cap;
      logic [9:0]  byte_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_CAP,
      ST_MUL,
      ST_BUILD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic build_zero;
      logic byte_pick;
      logic div_start;
      logic div_step;
      logic cap;
      logic mul;
      logic build;
   } cmd_type;

   typedef struct packed {
      logic zero_size;
      logic block_step;
      logic div_last;
      logic out_last;
   } stat_type;

   function automatic logic [9:0] pad_pow2(input logic [9:0] n);
      logic [9:0] p;
      p = BYTE_CHUNK_MAX;
      for (int i = 9; i >= 0; i--) begin
         if (n <= 10'(1 << i)) p = 10'(1 << i);
      end
      return p;
   endfunction

endpackage

>>> hw/rtl/sdio_xts_ctrl.sv
// sequencing state machine for the transfer splitter
module sdio_xts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sdio_xts_pkg::stat_type st,
   output sdio_xts_pkg::cmd_type  cmd
);

   sdio_xts_pkg::state_type state_ff;
   sdio_xts_pkg::state_type state_in;

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && (state_ff == sdio_xts_pkg::ST_IDLE);
   assign rsp_take = (state_ff == sdio_xts_pkg::ST_EMIT) && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdio_xts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdio_xts_pkg::ST_IDLE: begin
            if (req_take) state_in = sdio_xts_pkg::ST_STEP;
         end
         sdio_xts_pkg::ST_STEP: begin
            priority if (st.zero_size) state_in = sdio_xts_pkg::ST_EMIT;
            else if (st.block_step) state_in = sdio_xts_pkg::ST_DIV;
            else state_in = sdio_xts_pkg::ST_BUILD;
         end
         sdio_xts_pkg::ST_DIV: begin
            if (st.div_last) state_in = sdio_xts_pkg::ST_CAP;
         end
         sdio_xts_pkg::ST_CAP:   state_in = sdio_xts_pkg::ST_MUL;
         sdio_xts_pkg::ST_MUL:   state_in = sdio_xts_pkg::ST_BUILD;
         sdio_xts_pkg::ST_BUILD: state_in = sdio_xts_pkg::ST_EMIT;
         sdio_xts_pkg::ST_EMIT: begin
            if (rsp_take) begin
               state_in = st.out_last ? sdio_xts_pkg::ST_IDLE : sdio_xts_pkg::ST_STEP;
            end
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != sdio_xts_pkg::ST_IDLE);
      rsp_valid = (state_ff == sdio_xts_pkg::ST_EMIT);
      unique case (state_ff)
         sdio_xts_pkg::ST_IDLE:  cmd.load = req_take;
         sdio_xts_pkg::ST_STEP: begin
            priority if (st.zero_size) cmd.build_zero = 1'b1;
            else if (st.block_step) cmd.div_start = 1'b1;
            else cmd.byte_pick = 1'b1;
         end
         sdio_xts_pkg::ST_DIV:   cmd.div_step = 1'b1;
         sdio_xts_pkg::ST_CAP:   cmd.cap = 1'b1;
         sdio_xts_pkg::ST_MUL:   cmd.mul = 1'b1;
         sdio_xts_pkg::ST_BUILD: cmd.build = 1'b1;
         sdio_xts_pkg::ST_EMIT:  cmd = '0;
      endcase
   end

endmodule

>>> hw/rtl/sdio_xts_dp.sv
// datapath: request registers, block divider, multiplier and argument builder
module sdio_xts_dp #(
   parameter int MAX_COMMANDS = 64
) (
   input  logic                  clock,
   input  sdio_xts_pkg::cmd_type  cmd,
   input  sdio_xts_pkg::req_type  req_data,
   input  sdio_xts_pkg::cfg_type  cfg,
   output sdio_xts_pkg::stat_type st,
   output sdio_xts_pkg::rsp_type  rsp_data
);

   localparam int SZ = sdio_xts_pkg::SIZE_BITS;
   localparam int DCW = sdio_xts_pkg::DIV_CNT_W;
   localparam int CNT_W = $clog2(MAX_COMMANDS);
   localparam logic [CNT_W-1:0] LAST_N = CNT_W'(MAX_COMMANDS - 1);

   logic                 wr_ff;
   logic [2:0]           fn_ff;
   logic                 incr_ff;
   logic [16:0]          addr_ff;
   logic                 addr_over_ff;
   logic [SZ-1:0]        rem_ff;
   logic                 phase_ff;
   logic [CNT_W-1:0]     n_ff;
   logic [SZ-1:0]        quo_ff;
   logic [11:0]          part_ff;
   logic [DCW-1:0]       div_cnt_ff;
   logic [8:0]           blocks_ff;
   logic [SZ-1:0]        payload_ff;
   logic [11:0]          blen_ff;
   sdio_xts_pkg::rsp_type out_ff;

   logic [12:0]   shifted;
   logic          ge;
   logic [9:0]    pick;
   logic [20:0]   product;
   logic [SZ-1:0] rem_next;
   logic [20:0]   addr_sum;
   logic          byte_mode;
   logic [8:0]    count;
   logic          limit_hit;
   logic          load_phase;

   assign shifted   = {part_ff, quo_ff[SZ-1]};
   assign ge        = shifted >= {1'b0, cfg.block_size};
   assign pick      = (32'(rem_ff) < 32'(cfg.byte_limit)) ? rem_ff[9:0] : cfg.byte_limit;
   assign product   = 21'(blocks_ff) * 21'(cfg.block_size);
   assign rem_next  = rem_ff - payload_ff;
   assign addr_sum  = 21'(addr_ff) + 21'(payload_ff);
   assign byte_mode = (blocks_ff == 9'd1) && (blen_ff <= sdio_xts_pkg::BYTE_CODE_MAX);
   assign count     = byte_mode ? blen_ff[8:0] : blocks_ff;
   assign limit_hit = (n_ff == LAST_N) && (rem_ff != payload_ff);
   assign load_phase = cfg.blk_mode_en && (cfg.block_size != 12'd0)
                     && (32'(req_data.transfer_size) > 32'(cfg.byte_limit));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wr_ff        <= req_data.write;
         fn_ff        <= req_data.function_number;
         incr_ff      <= req_data.increment_address;
         addr_ff      <= req_data.start_address;
         addr_over_ff <= 1'b0;
         rem_ff       <= req_data.transfer_size;
         n_ff         <= '0;
         phase_ff     <= load_phase;
      end
      if (cmd.byte_pick) begin
         phase_ff   <= 1'b0;
         payload_ff <= SZ'(pick);
         blen_ff    <= 12'(sdio_xts_pkg::pad_pow2(pick));
         blocks_ff  <= 9'd1;
      end
      if (cmd.div_start) begin
         quo_ff     <= rem_ff;
         part_ff    <= '0;
         div_cnt_ff <= DCW'(SZ);
      end
      if (cmd.div_step) begin
         part_ff    <= ge ? 12'(shifted - {1'b0, cfg.block_size}) : shifted[11:0];
         quo_ff     <= {quo_ff[SZ-2:0], ge};
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end
      if (cmd.cap) begin
         blocks_ff <= (32'(quo_ff) > 32'(cfg.blk_cap)) ? cfg.blk_cap : quo_ff[8:0];
         blen_ff   <= cfg.block_size;
      end
      if (cmd.mul) begin
         payload_ff <= product[SZ-1:0];
      end
      if (cmd.build_zero) begin
         out_ff <= '{command_valid: 1'b0, command_argument: 32'd0, payload_bytes: 16'd0,
                     bus_bytes: 20'd0, status: sdio_xts_pkg::STATUS_OK, last: 1'b1};
      end
      if (cmd.build) begin
         priority if (addr_over_ff) begin
            out_ff <= '{command_valid: 1'b0, command_argument: 32'd0, payload_bytes: 16'd0,
                        bus_bytes: 20'd0, status: sdio_xts_pkg::STATUS_ADDR_ERR, last: 1'b1};
         end else if (limit_hit) begin
            out_ff <= '{command_valid: 1'b0, command_argument: 32'd0, payload_bytes: 16'd0,
                        bus_bytes: 20'd0, status: sdio_xts_pkg::STATUS_LIMIT, last: 1'b1};
         end else begin
            out_ff.command_valid    <= 1'b1;
            out_ff.command_argument <= {wr_ff, fn_ff, !byte_mode, incr_ff, addr_ff, count};
            out_ff.payload_bytes    <= 16'(payload_ff);
            out_ff.bus_bytes        <= phase_ff ? 20'(payload_ff) : 20'(blen_ff);
            out_ff.status           <= sdio_xts_pkg::STATUS_OK;
            out_ff.last             <= (rem_next == '0);
            rem_ff <= rem_next;
            n_ff   <= n_ff + CNT_W'(1);
            if (incr_ff) begin
               addr_ff      <= addr_sum[16:0];
               addr_over_ff <= addr_sum > 21'(sdio_xts_pkg::ADDR_MAX);
            end
         end
      end
   end

   assign st.zero_size  = (rem_ff == '0);
   assign st.block_step = phase_ff && (32'(rem_ff) > 32'(cfg.block_size));
   assign st.div_last   = (div_cnt_ff == DCW'(1));
   assign st.out_last   = out_ff.last;
   assign rsp_data      = out_ff;

endmodule

>>> hw/rtl/sdio_xts_cfg.sv
// configuration registers and their clamped working values
module sdio_xts_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [11:0]          csr_wdata,
   output sdio_xts_pkg::cfg_type cfg
);

   logic [11:0] block_size_ff;
   logic        blk_mode_en_ff;
   logic [8:0]  blk_cap_ff;
   logic [9:0]  byte_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= 12'd512;
         blk_mode_en_ff <= 1'b0;
         blk_cap_ff     <= 9'd511;
         byte_limit_ff  <= 10'd512;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sdio_xts_pkg::CSR_BLOCK_SIZE:  block_size_ff  <= csr_wdata;
            sdio_xts_pkg::CSR_BLK_MODE_EN: blk_mode_en_ff <= csr_wdata[0];
            sdio_xts_pkg::CSR_BLK_CAP:     blk_cap_ff     <= csr_wdata[8:0];
            sdio_xts_pkg::CSR_BYTE_LIMIT:  byte_limit_ff  <= csr_wdata[9:0];
         endcase
      end
   end

   always_comb begin
      cfg.block_size = (block_size_ff > sdio_xts_pkg::BLOCK_SIZE_MAX)
                     ? sdio_xts_pkg::BLOCK_SIZE_MAX : block_size_ff;
      cfg.blk_mode_en = blk_mode_en_ff;
      cfg.blk_cap = (blk_cap_ff == 9'd0) ? 9'd1 : blk_cap_ff;
      priority if (byte_limit_ff == 10'd0) cfg.byte_limit = 10'd1;
      else if (byte_limit_ff > sdio_xts_pkg::BYTE_CHUNK_MAX)
         cfg.byte_limit = sdio_xts_pkg::BYTE_CHUNK_MAX;
      else cfg.byte_limit = byte_limit_ff;
   end

endmodule

>>> hw/rtl/sdio_extended_transfer_splitter_core.sv
// sdio extended transfer splitter top level
//
// a request beat on req_ carries one transfer (direction, function, start
// address, increment flag, byte count); the block answers with a run of
// rsp_ beats, one per cmd53 argument word, the final one flagged by last.
// a zero-size request yields a beat with command_valid low and status ok;
// an address overflow or the command limit yields such a beat with an error status.
// req_stall stays high from the accepted request until the last rsp beat
// of its run is taken; one request is in flight at a time.
// each rsp beat is prepared in the states step, build and emit in byte
// mode; block mode adds div, cap and mul after step, with div run by the
// one-bit-per-cycle block-count divider.
// while rsp_stall is high the result beat is held unchanged in the output
// register and the sequencer waits.
// csr_ writes are always ready and are meant to happen between requests.
// synchronous reset returns the sequencer to idle and loads the register
// defaults: block size 512, block mode off, 511 blocks, byte limit 512.
module sdio_extended_transfer_splitter_core #(
   parameter int MAX_COMMANDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sdio_xts_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sdio_xts_pkg::rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [11:0]           csr_wdata
);

   sdio_xts_pkg::cfg_type  cfg;
   sdio_xts_pkg::cmd_type  cmd;
   sdio_xts_pkg::stat_type st;

   sdio_xts_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdio_xts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   sdio_xts_dp #(
      .MAX_COMMANDS (MAX_COMMANDS)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg),
      .st       (st),
      .rsp_data (rsp_data)
   );

   a_busy_while_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result beat is pending");

   a_error_ends_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != sdio_xts_pkg::STATUS_OK)) |-> rsp_data.last)
      else $error("error status on a beat that is not last");

   a_no_cmd_no_arg : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.command_valid) |-> (rsp_data.command_argument == 32'd0))
      else $error("argument set on a beat without a command");

   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=> !req_stall)
      else $error("not ready for a new request after the last beat");

endmodule
